// File: rtl/core/nqla_pkg.sv
package nqla_pkg;

	localparam logic [1:0] FUNC_LOCK    = 2'd0;
	localparam logic [1:0] FUNC_TRYLOCK = 2'd1;
	localparam logic [1:0] FUNC_UNLOCK  = 2'd2;

	localparam logic [2:0] ST_ACQUIRED = 3'd0;
	localparam logic [2:0] ST_QUEUED   = 3'd1;
	localparam logic [2:0] ST_BUSY     = 3'd2;
	localparam logic [2:0] ST_RELEASED = 3'd3;
	localparam logic [2:0] ST_ERROR    = 3'd4;

	localparam logic [31:0] LOCAL_MASK = 32'h0000ffff;

	typedef struct packed {
		logic load;
		logic decide;
		logic rng_rd;
		logic unlock_a;
		logic walk_rd;
		logic walk_eval;
		logic fin_rd;
		logic finish;
	} nqla_cmd_t;

	typedef struct packed {
		logic is_unlock;
		logic keep_local;
		logic need_walk;
		logic walk_found;
		logic walk_end;
	} nqla_stat_t;

endpackage

// File: rtl/core/nqla_ram.sv
module nqla_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// File: rtl/core/nqla_ctrl.sv
module nqla_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	output nqla_pkg::nqla_cmd_t cmd,
	input  nqla_pkg::nqla_stat_t stat
);

	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_DEC    = 3'd1;
	localparam logic [2:0] S_RNG    = 3'd2;
	localparam logic [2:0] S_UNA    = 3'd3;
	localparam logic [2:0] S_WRD    = 3'd4;
	localparam logic [2:0] S_WEV    = 3'd5;
	localparam logic [2:0] S_FRD    = 3'd6;
	localparam logic [2:0] S_FIN    = 3'd7;

	logic [2:0] state_q;
	logic [2:0] state_d;

	assign busy = (state_q != S_IDLE);

	always_comb begin
		cmd = '0;
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					state_d = S_DEC;
				end
			end
			S_DEC: begin
				cmd.decide = 1'b1;
				state_d = stat.is_unlock ? S_RNG : S_IDLE;
			end
			S_RNG: begin
				cmd.rng_rd = 1'b1;
				state_d = S_UNA;
			end
			S_UNA: begin
				cmd.unlock_a = 1'b1;
				state_d = stat.need_walk ? S_WRD : S_FRD;
			end
			S_WRD: begin
				cmd.walk_rd = 1'b1;
				state_d = S_WEV;
			end
			S_WEV: begin
				cmd.walk_eval = 1'b1;
				state_d = (stat.walk_found || stat.walk_end) ? S_FRD : S_WRD;
			end
			S_FRD: begin
				cmd.fin_rd = 1'b1;
				state_d = S_FIN;
			end
			S_FIN: begin
				cmd.finish = 1'b1;
				state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

// File: rtl/core/nqla_dp.sv
module nqla_dp #(
	parameter int THREADS    = 64,
	parameter int LOCAL_ODDS = 1024
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  nqla_pkg::nqla_cmd_t  cmd,
	output nqla_pkg::nqla_stat_t stat,
	input  logic [1:0]           func,
	input  logic [5:0]           thread_id,
	input  logic [1:0]           socket,
	output logic                 done,
	output logic [2:0]           status,
	output logic                 grant_valid,
	output logic [5:0]           grant_thread
);

	localparam int AW = $clog2(THREADS);
	localparam logic [31:0] ODDS_MASK = 32'(LOCAL_ODDS - 1) & nqla_pkg::LOCAL_MASK;

	logic [1:0]  func_q;
	logic [5:0]  t_q;
	logic [1:0]  s_q;
	logic        in_range;
	logic [AW-1:0] ti;

	logic        holder_valid_q, holder_known_q;
	logic [5:0]  holder_thread_q;
	logic [1:0]  holder_socket_q;
	logic        main_ne_q, sec_ne_q;
	logic [5:0]  main_head_q, main_last_q, sec_head_q, sec_last_q;
	logic [THREADS-1:0] waiting_q;
	logic [THREADS-1:0] seeded_q;

	logic [5:0]  cur_q, prev_q, succ_q;
	logic        first_q, keep_q, want_fin_q;
	logic [1:0]  my_sock_q;

	logic        done_q;
	logic [2:0]  status_q;
	logic        gv_q;
	logic [5:0]  gt_q;

	logic          link_we, sock_we, rng_we;
	logic [AW-1:0] link_wa, link_ra;
	logic [5:0]    link_wd, link_rd;
	logic [AW-1:0] sock_ra;
	logic [1:0]    sock_rd;
	logic [31:0]   rng_rd, rng_wd, v0, v1, v2, v3;

	assign in_range = ({26'd0, t_q} < 32'(THREADS));
	assign ti = AW'(t_q);

	nqla_ram #(.WIDTH(6), .DEPTH(THREADS)) u_link (
		.clk(clk), .we(link_we), .waddr(link_wa), .wdata(link_wd),
		.raddr(link_ra), .rdata(link_rd)
	);
	nqla_ram #(.WIDTH(2), .DEPTH(THREADS)) u_sock (
		.clk(clk), .we(sock_we), .waddr(ti), .wdata(s_q),
		.raddr(sock_ra), .rdata(sock_rd)
	);
	nqla_ram #(.WIDTH(32), .DEPTH(THREADS)) u_rng (
		.clk(clk), .we(rng_we), .waddr(ti), .wdata(rng_wd),
		.raddr(ti), .rdata(rng_rd)
	);

	logic known, is_holder;
	assign is_holder = holder_valid_q && (holder_thread_q == t_q);
	assign known = is_holder || waiting_q[ti];

	assign v0 = seeded_q[ti] ? rng_rd : 32'({26'd0, t_q} + 32'd1);
	assign v1 = v0 ^ (v0 << 6);
	assign v2 = v1 ^ (v1 >> 21);
	assign v3 = v2 ^ (v2 << 7);
	assign rng_wd = (v3 == 32'd0) ? 32'd0 : v3;

	always_comb begin
		stat.is_unlock = in_range && (func_q == nqla_pkg::FUNC_UNLOCK) && is_holder
			&& (main_ne_q || sec_ne_q);
		stat.keep_local = (v3 & ODDS_MASK) != 32'd0;
		stat.need_walk = main_ne_q && stat.keep_local;
		stat.walk_found = (sock_rd == my_sock_q);
		stat.walk_end = (cur_q == main_last_q);
	end

	always_comb begin
		link_we = 1'b0;
		link_wa = AW'(main_last_q);
		link_wd = t_q;
		sock_we = 1'b0;
		rng_we = 1'b0;
		link_ra = AW'(cur_q);
		sock_ra = AW'(cur_q);
		if (cmd.decide && in_range && !known && holder_valid_q
			&& func_q == nqla_pkg::FUNC_LOCK) begin
			sock_we = 1'b1;
			link_we = main_ne_q;
		end
		if (cmd.unlock_a && main_ne_q) begin
			rng_we = 1'b1;
		end
		if (cmd.walk_eval && stat.walk_found && !first_q) begin
			link_we = sec_ne_q;
			link_wa = AW'(sec_last_q);
			link_wd = main_head_q;
		end
		if (cmd.fin_rd) begin
			link_ra = AW'(succ_q);
			sock_ra = AW'(succ_q);
		end
		if (cmd.finish && want_fin_q && sec_head_q != sec_last_q && sec_ne_q) begin
			link_we = 1'b1;
			link_wa = AW'(sec_last_q);
			link_wd = main_head_q;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			func_q <= func;
			t_q <= thread_id;
			s_q <= socket;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			holder_valid_q <= 1'b0;
			holder_known_q <= 1'b0;
			holder_thread_q <= '0;
			holder_socket_q <= '0;
			main_ne_q <= 1'b0;
			sec_ne_q <= 1'b0;
			main_head_q <= '0;
			main_last_q <= '0;
			sec_head_q <= '0;
			sec_last_q <= '0;
			waiting_q <= '0;
			seeded_q <= '0;
			cur_q <= '0;
			prev_q <= '0;
			succ_q <= '0;
			first_q <= 1'b0;
			keep_q <= 1'b0;
			want_fin_q <= 1'b0;
			my_sock_q <= '0;
			done_q <= 1'b0;
			status_q <= '0;
			gv_q <= 1'b0;
			gt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (cmd.decide) begin
				gv_q <= 1'b0;
				gt_q <= '0;
				if (!in_range) begin
					done_q <= 1'b1;
					status_q <= nqla_pkg::ST_ERROR;
				end else if (func_q == nqla_pkg::FUNC_LOCK
					|| func_q == nqla_pkg::FUNC_TRYLOCK) begin
					done_q <= 1'b1;
					if (known) begin
						status_q <= nqla_pkg::ST_ERROR;
					end else if (!holder_valid_q) begin
						holder_valid_q <= 1'b1;
						holder_thread_q <= t_q;
						holder_socket_q <= '0;
						holder_known_q <= 1'b0;
						status_q <= nqla_pkg::ST_ACQUIRED;
					end else if (func_q == nqla_pkg::FUNC_TRYLOCK) begin
						status_q <= nqla_pkg::ST_BUSY;
					end else begin
						waiting_q[ti] <= 1'b1;
						if (!main_ne_q) begin
							main_head_q <= t_q;
						end
						main_last_q <= t_q;
						main_ne_q <= 1'b1;
						status_q <= nqla_pkg::ST_QUEUED;
					end
				end else if (func_q == nqla_pkg::FUNC_UNLOCK && is_holder) begin
					if (!main_ne_q && !sec_ne_q) begin
						done_q <= 1'b1;
						holder_valid_q <= 1'b0;
						holder_known_q <= 1'b0;
						status_q <= nqla_pkg::ST_RELEASED;
					end
				end else begin
					done_q <= 1'b1;
					status_q <= nqla_pkg::ST_ERROR;
				end
			end
			if (cmd.unlock_a) begin
				cur_q <= main_head_q;
				prev_q <= main_head_q;
				first_q <= 1'b1;
				my_sock_q <= holder_known_q ? holder_socket_q : s_q;
				want_fin_q <= 1'b0;
				if (!main_ne_q) begin
					succ_q <= sec_head_q;
					if (sec_head_q != sec_last_q) begin
						main_head_q <= 6'd0;
						main_last_q <= sec_last_q;
						main_ne_q <= 1'b1;
						keep_q <= 1'b1;
					end else begin
						keep_q <= 1'b0;
					end
					sec_ne_q <= 1'b0;
				end else begin
					seeded_q[ti] <= 1'b1;
					keep_q <= 1'b0;
					if (!stat.keep_local) begin
						want_fin_q <= 1'b1;
						succ_q <= sec_ne_q ? sec_head_q : main_head_q;
					end
				end
			end
			if (cmd.walk_eval) begin
				if (stat.walk_found) begin
					if (!first_q) begin
						if (!sec_ne_q) begin
							sec_head_q <= main_head_q;
						end
						sec_last_q <= prev_q;
						sec_ne_q <= 1'b1;
					end
					succ_q <= cur_q;
					keep_q <= 1'b0;
					if (cur_q == main_last_q) begin
						main_ne_q <= 1'b0;
					end else begin
						main_head_q <= link_rd;
					end
				end else if (cur_q == main_last_q) begin
					want_fin_q <= 1'b1;
					succ_q <= sec_ne_q ? sec_head_q : main_head_q;
				end else begin
					prev_q <= cur_q;
					cur_q <= link_rd;
					first_q <= 1'b0;
				end
			end
			if (cmd.finish) begin
				if (keep_q) begin
					main_head_q <= link_rd;
				end
				if (want_fin_q) begin
					if (sec_ne_q) begin
						if (sec_head_q != sec_last_q) begin
							main_head_q <= link_rd;
						end
						sec_ne_q <= 1'b0;
					end else if (main_head_q == main_last_q) begin
						main_ne_q <= 1'b0;
					end else begin
						main_head_q <= link_rd;
					end
				end
				waiting_q[AW'(succ_q)] <= 1'b0;
				holder_thread_q <= succ_q;
				holder_socket_q <= sock_rd;
				holder_known_q <= 1'b1;
				done_q <= 1'b1;
				status_q <= nqla_pkg::ST_RELEASED;
				gv_q <= 1'b1;
				gt_q <= succ_q;
			end
		end
	end

	assign done = done_q;
	assign status = status_q;
	assign grant_valid = gv_q;
	assign grant_thread = gt_q;

endmodule

// File: rtl/core/numa_aware_queue_lock_arbiter.sv
// Channel   Signals                               Transfer
// request   start, func, thread_id, socket        start high while busy is low
// result    done, status, grant_valid, grant_thread  done high for one cycle
//
// Lock, trylock, an error and a plain release are answered from S_DEC via the
// registered done. An unlock with a handoff runs S_DEC, S_RNG and S_UNA, then
// the socket search if needed (S_WRD, S_WEV per main waiter visited, one link
// RAM read each), S_FRD and S_FIN. Reset clears the holder, queues and flags.
// The result cannot be stalled; the next request is taken once busy falls.
module numa_aware_queue_lock_arbiter #(
	parameter int THREADS    = 64,
	parameter int LOCAL_ODDS = 1024
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	output logic       busy,
	input  logic [1:0] func,
	input  logic [5:0] thread_id,
	input  logic [1:0] socket,
	output logic       done,
	output logic [2:0] status,
	output logic       grant_valid,
	output logic [5:0] grant_thread
);

	nqla_pkg::nqla_cmd_t  cmd;
	nqla_pkg::nqla_stat_t stat;

	nqla_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.cmd(cmd), .stat(stat)
	);

	nqla_dp #(.THREADS(THREADS), .LOCAL_ODDS(LOCAL_ODDS)) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .stat(stat),
		.func(func), .thread_id(thread_id), .socket(socket),
		.done(done), .status(status), .grant_valid(grant_valid),
		.grant_thread(grant_thread)
	);

endmodule

// File: tb/sv/tb_numa_aware_queue_lock_arbiter.sv
`timescale 1ns / 100ps

module tb_numa_aware_queue_lock_arbiter;

	localparam int NTHR = 64;
	localparam int ODDS = 1024;
	localparam longint CYCLE_LIMIT = 400000;
	localparam logic [1:0] FUNC_BAD = 2'd3;

	typedef struct packed {
		logic [1:0] func;
		logic [5:0] thread_id;
		logic [1:0] socket;
	} lock_req_t;

	typedef struct packed {
		logic [2:0] status;
		logic       grant_valid;
		logic [5:0] grant_thread;
	} lock_rsp_t;

	logic       clk;
	logic       arst_n;
	logic       start;
	logic       busy;
	logic [1:0] func;
	logic [5:0] thread_id;
	logic [1:0] socket;
	logic       done;
	logic [2:0] status;
	logic       grant_valid;
	logic [5:0] grant_thread;

	numa_aware_queue_lock_arbiter u_dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.func(func), .thread_id(thread_id), .socket(socket),
		.done(done), .status(status), .grant_valid(grant_valid),
		.grant_thread(grant_thread)
	);

	// Lock state mirror.
	logic        hold_v;
	logic [5:0]  hold_t;
	logic [1:0]  hold_s;
	logic        hold_known;
	logic        mq_v, sq_v;
	logic [5:0]  mq_head, mq_last, sq_head, sq_last;
	logic [5:0]  next_of [NTHR];
	logic [1:0]  wait_sock [NTHR];
	logic        waiting [NTHR];
	logic [31:0] xs_word [NTHR];

	lock_req_t pending_reqs[$];
	lock_rsp_t expected_rsps[$];
	longint    cycle_count;
	int        n_errors;
	int        n_rsps;
	int        n_grants;
	int        n_local;
	bit        stim_done;
	bit        quiet_phase;

	initial clk = 1'b0;
	always #4 clk = ~clk;

	function automatic bit step_xorshift(input logic [5:0] t);
		logic [31:0] v;
		v = xs_word[t];
		if (v == 32'd0)
			v = {26'd0, t} + 32'd1;
		v = v ^ (v << 6);
		v = v ^ (v >> 21);
		v = v ^ (v << 7);
		xs_word[t] = v;
		return ((v & (ODDS - 1)) & nqla_pkg::LOCAL_MASK) != 32'd0;
	endfunction

	function automatic bit find_local(input logic [1:0] s, output logic [5:0] succ);
		logic [5:0] cur;
		logic [5:0] prev;
		bit         first;
		cur = mq_head;
		prev = mq_head;
		first = 1;
		for (int i = 0; i < NTHR; i++) begin
			if (wait_sock[cur] == s) begin
				if (!first) begin
					if (sq_v)
						next_of[sq_last] = mq_head;
					else
						sq_head = mq_head;
					sq_last = prev;
					sq_v = 1'b1;
				end
				if (cur == mq_last)
					mq_v = 1'b0;
				else
					mq_head = next_of[cur];
				succ = cur;
				return 1;
			end
			if (cur == mq_last)
				return 0;
			prev = cur;
			cur = next_of[cur];
			first = 0;
		end
		return 0;
	endfunction

	function automatic lock_rsp_t predict_lock(input lock_req_t r);
		lock_rsp_t  o;
		logic [5:0] t;
		logic [5:0] succ;
		logic [1:0] my_s;
		bit         known;
		bit         granted;
		o = '0;
		o.status = nqla_pkg::ST_ERROR;
		t = r.thread_id;
		granted = 0;
		known = (hold_v && hold_t == t) || waiting[t];
		if (r.func == nqla_pkg::FUNC_LOCK || r.func == nqla_pkg::FUNC_TRYLOCK) begin
			if (known) begin
				o.status = nqla_pkg::ST_ERROR;
			end else if (!hold_v) begin
				hold_v = 1'b1;
				hold_t = t;
				hold_s = 2'd0;
				hold_known = 1'b0;
				o.status = nqla_pkg::ST_ACQUIRED;
			end else if (r.func == nqla_pkg::FUNC_TRYLOCK) begin
				o.status = nqla_pkg::ST_BUSY;
			end else begin
				wait_sock[t] = r.socket;
				waiting[t] = 1'b1;
				if (mq_v)
					next_of[mq_last] = t;
				else
					mq_head = t;
				mq_last = t;
				mq_v = 1'b1;
				o.status = nqla_pkg::ST_QUEUED;
			end
		end else if (r.func == nqla_pkg::FUNC_UNLOCK && hold_v && hold_t == t) begin
			o.status = nqla_pkg::ST_RELEASED;
			if (!mq_v) begin
				if (!sq_v) begin
					hold_v = 1'b0;
					hold_known = 1'b0;
				end else begin
					succ = sq_head;
					if (sq_head != sq_last) begin
						mq_head = next_of[sq_head];
						mq_last = sq_last;
						mq_v = 1'b1;
					end
					sq_v = 1'b0;
					granted = 1;
				end
			end else begin
				my_s = hold_known ? hold_s : r.socket;
				granted = 1;
				if (step_xorshift(t) && find_local(my_s, succ)) begin
					n_local++;
				end else if (sq_v) begin
					succ = sq_head;
					if (sq_head != sq_last) begin
						next_of[sq_last] = mq_head;
						mq_head = next_of[sq_head];
					end
					sq_v = 1'b0;
				end else begin
					succ = mq_head;
					if (mq_head == mq_last)
						mq_v = 1'b0;
					else
						mq_head = next_of[mq_head];
				end
			end
			if (granted) begin
				waiting[succ] = 1'b0;
				hold_t = succ;
				hold_s = wait_sock[succ];
				hold_known = 1'b1;
				o.grant_valid = 1'b1;
				o.grant_thread = succ;
			end
		end
		return o;
	endfunction

	// Driver: prediction happens at the accepting edge, in transfer order.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start <= 1'b0;
			func <= nqla_pkg::FUNC_LOCK;
			thread_id <= '0;
			socket <= '0;
		end else begin
			if (start && !busy)
				expected_rsps.push_back(predict_lock({func, thread_id, socket}));
			if (!(start && busy)) begin
				if (pending_reqs.size() > 0 && (quiet_phase || $urandom_range(99) >= 11)) begin
					{func, thread_id, socket} <= pending_reqs.pop_front();
					start <= 1'b1;
				end else begin
					start <= 1'b0;
				end
			end
		end
	end

	// Monitor.
	always @(posedge clk) begin
		lock_rsp_t exp_r;
		if (arst_n && done) begin
			if (expected_rsps.size() == 0) begin
				$error("result with nothing expected: status %0d", status);
				n_errors++;
			end else begin
				exp_r = expected_rsps.pop_front();
				n_rsps++;
				if (grant_valid)
					n_grants++;
				if (status !== exp_r.status) begin
					$error("status: expected %0d, actual %0d", exp_r.status, status);
					n_errors++;
				end
				if (grant_valid !== exp_r.grant_valid) begin
					$error("grant_valid: expected %0d, actual %0d",
						exp_r.grant_valid, grant_valid);
					n_errors++;
				end
				if (grant_thread !== exp_r.grant_thread) begin
					$error("grant_thread: expected %0d, actual %0d",
						exp_r.grant_thread, grant_thread);
					n_errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycle_count);
			$display("numa_aware_queue_lock_arbiter verification failed");
			$finish;
		end
	end

	task automatic add_req(input logic [1:0] f, input int t, input int s);
		pending_reqs.push_back({f, 6'(t), 2'(s)});
	endtask

	// Random traffic drawn mostly from a small thread pool so that queues grow long.
	task automatic add_random(input int count);
		int t;
		int r;
		for (int i = 0; i < count; i++) begin
			r = $urandom_range(99);
			t = ($urandom_range(3) == 0) ? $urandom_range(63) : $urandom_range(15);
			if (r < 50)
				add_req(nqla_pkg::FUNC_LOCK, t, $urandom_range(3));
			else if (r < 60)
				add_req(nqla_pkg::FUNC_TRYLOCK, t, $urandom_range(3));
			else if (r < 62)
				add_req(FUNC_BAD, t, $urandom_range(3));
			else
				add_req(nqla_pkg::FUNC_UNLOCK, t, $urandom_range(3));
		end
	endtask

	// Unlocks from thread 63; they drain the queues through handoffs only while it holds the lock.
	task automatic add_drain(input int count);
		for (int i = 0; i < count; i++)
			pending_reqs.push_back({nqla_pkg::FUNC_UNLOCK, 6'd63, 2'(0)});
	endtask

	initial begin
		cycle_count = 0;
		n_errors = 0;
		n_rsps = 0;
		n_grants = 0;
		n_local = 0;
		stim_done = 0;
		quiet_phase = 0;
		hold_v = 0; hold_t = 0; hold_s = 0; hold_known = 0;
		mq_v = 0; sq_v = 0; mq_head = 0; mq_last = 0; sq_head = 0; sq_last = 0;
		for (int i = 0; i < NTHR; i++) begin
			next_of[i] = '0;
			wait_sock[i] = '0;
			waiting[i] = 1'b0;
			xs_word[i] = '0;
		end
		arst_n = 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		add_req(nqla_pkg::FUNC_UNLOCK, 0, 0);
		add_req(nqla_pkg::FUNC_LOCK, 0, 3);
		add_req(nqla_pkg::FUNC_LOCK, 0, 1);
		add_req(nqla_pkg::FUNC_TRYLOCK, 63, 0);
		add_req(nqla_pkg::FUNC_LOCK, 63, 3);
		add_req(nqla_pkg::FUNC_TRYLOCK, 63, 3);
		add_req(nqla_pkg::FUNC_LOCK, 5, 2);
		add_req(nqla_pkg::FUNC_LOCK, 6, 1);
		add_req(nqla_pkg::FUNC_LOCK, 7, 0);
		add_req(FUNC_BAD, 7, 0);
		add_req(nqla_pkg::FUNC_UNLOCK, 5, 2);
		add_req(nqla_pkg::FUNC_UNLOCK, 0, 2);
		add_req(nqla_pkg::FUNC_UNLOCK, 5, 0);
		add_req(nqla_pkg::FUNC_UNLOCK, 6, 0);
		add_req(nqla_pkg::FUNC_UNLOCK, 7, 3);
		add_req(nqla_pkg::FUNC_UNLOCK, 63, 0);
		add_req(nqla_pkg::FUNC_UNLOCK, 63, 0);
		add_req(nqla_pkg::FUNC_TRYLOCK, 42, 1);
		add_req(nqla_pkg::FUNC_UNLOCK, 42, 1);
		add_req(nqla_pkg::FUNC_TRYLOCK, 21, 2);
		add_req(nqla_pkg::FUNC_UNLOCK, 21, 2);

		add_random(300);
		quiet_phase = 1;
		while (pending_reqs.size() > 0)
			@(posedge clk);
		quiet_phase = 0;
		add_random(530);
		while (pending_reqs.size() > 0 || start)
			@(posedge clk);
		// Release whoever holds the lock, then every handoff until free.
		while (expected_rsps.size() > 0)
			@(posedge clk);
		while (hold_v) begin
			add_req(nqla_pkg::FUNC_UNLOCK, hold_t, 0);
			while (pending_reqs.size() > 0 || start || expected_rsps.size() > 0)
				@(posedge clk);
		end
		repeat (200) @(posedge clk);
		$display("%0d requests answered, %0d handoffs (%0d to a same-socket waiter)",
			n_rsps, n_grants, n_local);
		if (n_errors == 0 && expected_rsps.size() == 0)
			$display("numa_aware_queue_lock_arbiter verification clean");
		else
			$display("numa_aware_queue_lock_arbiter verification failed");
		$finish;
	end

endmodule
